// ===== src/matrix_multiply_unit_defines.svh =====
// Assertion macros shared by the matrix multiply unit RTL.
`ifndef MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MMU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix multiply unit: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix multiply unit: next-cycle check failed");

`endif

// ===== src/mmu_pkg.sv =====
// Package with types, constants and helpers of the matrix multiply unit.
`default_nettype none

package mmu_pkg;

   // Largest matrix dimension supported by default.
   localparam int MAX_DIM_DEF = 8;

   // Fixed field widths of the channels.
   localparam int REQ_TYPE_W = 2;
   localparam int INDEX_W    = 3;
   localparam int VALUE_W    = 16;
   localparam int SUM_W      = 36;
   localparam int PROD_W     = 2 * VALUE_W;
   localparam int DIM_W      = 4;

   // Configuration port widths.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_A  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_B  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_COMPUTE = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_ROWS_A = 2'd0;
   localparam logic [1:0] CSR_COLS_A = 2'd1;
   localparam logic [1:0] CSR_ROWS_B = 2'd2;
   localparam logic [1:0] CSR_COLS_B = 2'd3;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ERR
   } state_type;

   // A dimension register of zero acts as one, above the maximum as the maximum.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_dim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > max_dim) begin
         r = max_dim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/mmu_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface mmu_req_if;
   import mmu_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [REQ_TYPE_W-1:0]       req_type;
   logic [INDEX_W-1:0]          row_index;
   logic [INDEX_W-1:0]          col_index;
   logic signed [VALUE_W-1:0]   value;

   modport source (output valid, req_type, row_index, col_index, value, input ready);
   modport sink   (input valid, req_type, row_index, col_index, value, output ready);
endinterface

interface mmu_rsp_if;
   import mmu_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [INDEX_W-1:0]          out_row;
   logic [INDEX_W-1:0]          out_col;
   logic signed [SUM_W-1:0]     sum;
   logic                        last;
   logic                        dim_error;

   modport source (output valid, out_row, out_col, sum, last, dim_error, input ready);
   modport sink   (input valid, out_row, out_col, sum, last, dim_error, output ready);
endinterface

`default_nettype wire

// ===== src/mmu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mmu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; read data holds while re is low.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/matrix_multiply_unit.sv =====
// Matrix multiply unit: C = A x B over two element stores with a multiply-accumulate pipe.
//
// A load item writes one Q8.8 element of A or B; loads may arrive back to back.
// A compute item walks the stores with one read of each store and one
// multiply-accumulate per cycle while the result side does not stall; that rate
// is set by the single read port of each store. A dimension mismatch moves the
// sequencer to its error state, which loads the single error result into the
// output register once that register is free. New items are taken only while no
// run is in progress; results leave through an output register, so a finished
// result may wait while the next item is accepted. Store entries are undefined
// until written and have no clearing pass.
`default_nettype none
`include "matrix_multiply_unit_defines.svh"

module matrix_multiply_unit #(
   parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mmu_req_if.sink                              req,
   mmu_rsp_if.source                            rsp,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [mmu_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [mmu_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [mmu_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import mmu_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(MAX_DIM);

   // Configuration registers.
   logic [DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic             csr_write;

   // Sequencer.
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff;
   logic [IDX_W-1:0] i_in, j_in, k_in;
   logic             issue, en, stall, err_load, out_load, last_issue;
   logic             last_i, last_j, last_k;
   logic [DIM_W-1:0] n_dim, m_dim, p_dim, f_dim;

   // Input decode.
   logic             req_accept, ld_ok, we_a, we_b, start;
   logic [ADDR_W-1:0] ld_addr, rd_addr_a, rd_addr_b;
   logic [VALUE_W-1:0] rd_a, rd_b;

   // Pipeline stages: read data, product, accumulate.
   logic             s1_valid_ff, s1_first_ff, s1_lastk_ff, s1_lastall_ff;
   logic [IDX_W-1:0] s1_row_ff, s1_col_ff;
   logic             s2_valid_ff, s2_first_ff, s2_lastk_ff, s2_lastall_ff;
   logic [IDX_W-1:0] s2_row_ff, s2_col_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  acc_ff, acc_sum;

   // Output register.
   logic                    rsp_valid_ff;
   logic [INDEX_W-1:0]      out_row_ff, out_col_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic                    last_ff, dim_error_ff;

   // Configuration write and read-back.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= DIM_W'(8);
         cols_a_ff <= DIM_W'(8);
         rows_b_ff <= DIM_W'(8);
         cols_b_ff <= DIM_W'(8);
      end else if (csr_write) begin
         unique case (paddr[3:2])
            CSR_ROWS_A: rows_a_ff <= pwdata[DIM_W-1:0];
            CSR_COLS_A: cols_a_ff <= pwdata[DIM_W-1:0];
            CSR_ROWS_B: rows_b_ff <= pwdata[DIM_W-1:0];
            CSR_COLS_B: cols_b_ff <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_ROWS_A: prdata = CSR_DATA_W'(rows_a_ff);
         CSR_COLS_A: prdata = CSR_DATA_W'(cols_a_ff);
         CSR_ROWS_B: prdata = CSR_DATA_W'(rows_b_ff);
         CSR_COLS_B: prdata = CSR_DATA_W'(cols_b_ff);
         default:    prdata = '0;
      endcase
   end

   // Effective dimensions.
   assign n_dim = clamp_dim(rows_a_ff, DIM_W'(MAX_DIM));
   assign m_dim = clamp_dim(cols_a_ff, DIM_W'(MAX_DIM));
   assign p_dim = clamp_dim(rows_b_ff, DIM_W'(MAX_DIM));
   assign f_dim = clamp_dim(cols_b_ff, DIM_W'(MAX_DIM));

   // Input transfer decode; loads out of range are dropped.
   assign req_accept = req.valid && req.ready;
   assign ld_ok      = (DIM_W'(req.row_index) < DIM_W'(MAX_DIM)) &&
                       (DIM_W'(req.col_index) < DIM_W'(MAX_DIM));
   assign we_a       = req_accept && (req.req_type == REQ_LOAD_A) && ld_ok;
   assign we_b       = req_accept && (req.req_type == REQ_LOAD_B) && ld_ok;
   assign start      = req_accept && (req.req_type == REQ_COMPUTE);
   assign ld_addr    = ADDR_W'(32'(req.row_index) * 32'(MAX_DIM) + 32'(req.col_index));

   // Walk position.
   assign last_k     = (DIM_W'(k_ff) == m_dim - DIM_W'(1));
   assign last_j     = (DIM_W'(j_ff) == f_dim - DIM_W'(1));
   assign last_i     = (DIM_W'(i_ff) == n_dim - DIM_W'(1));
   assign last_issue = last_k && last_j && last_i;
   assign rd_addr_a  = ADDR_W'(32'(i_ff) * 32'(MAX_DIM) + 32'(k_ff));
   assign rd_addr_b  = ADDR_W'(32'(k_ff) * 32'(MAX_DIM) + 32'(j_ff));

   // The pipe stalls only when a finished element meets a full output register.
   assign stall    = s2_valid_ff && s2_lastk_ff && rsp_valid_ff && !rsp.ready;
   assign en       = !stall;
   assign out_load = s2_valid_ff && s2_lastk_ff && en;

   // Element stores.
   mmu_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_store_a (
      .clock (clock),
      .we    (we_a),
      .waddr (ld_addr),
      .wdata (req.value),
      .re    (issue && en),
      .raddr (rd_addr_a),
      .rdata (rd_a)
   );

   mmu_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_store_b (
      .clock (clock),
      .we    (we_b),
      .waddr (ld_addr),
      .wdata (req.value),
      .re    (issue && en),
      .raddr (rd_addr_b),
      .rdata (rd_b)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (m_dim != p_dim) ? ST_ERR : ST_RUN;
            end
         end
         ST_RUN: begin
            if (en && last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (err_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req.ready = 1'b0;
      issue     = 1'b0;
      err_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req.ready = 1'b1;
         ST_RUN:   issue     = 1'b1;
         ST_DRAIN: ;
         ST_ERR:   err_load  = !rsp_valid_ff || rsp.ready;
         default:  ;
      endcase
   end

   // Walk counters: k innermost, then column, then row.
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (start) begin
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end else if (issue && en) begin
         if (last_k) begin
            k_in = '0;
            if (last_j) begin
               j_in = '0;
               i_in = i_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end else begin
            k_in = k_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Pipeline tags and the product register.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_first_ff   <= (k_ff == '0);
         s1_lastk_ff   <= last_k;
         s1_lastall_ff <= last_j && last_i;
         s1_row_ff     <= i_ff;
         s1_col_ff     <= j_ff;
         s2_first_ff   <= s1_first_ff;
         s2_lastk_ff   <= s1_lastk_ff;
         s2_lastall_ff <= s1_lastall_ff;
         s2_row_ff     <= s1_row_ff;
         s2_col_ff     <= s1_col_ff;
         prod_ff       <= $signed(rd_a) * $signed(rd_b);
      end
   end

   // Accumulator; the first term of each dot product starts from zero.
   assign acc_sum = (s2_first_ff ? SUM_W'(0) : acc_ff) + SUM_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (en && s2_valid_ff) begin
         acc_ff <= acc_sum;
      end
   end

   // Output register: a product element or the error result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load || err_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_row_ff   <= INDEX_W'(s2_row_ff);
         out_col_ff   <= INDEX_W'(s2_col_ff);
         sum_ff       <= acc_sum;
         last_ff      <= s2_lastall_ff;
         dim_error_ff <= 1'b0;
      end else if (err_load) begin
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         sum_ff       <= '0;
         last_ff      <= 1'b1;
         dim_error_ff <= 1'b1;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_row   = out_row_ff;
   assign rsp.out_col   = out_col_ff;
   assign rsp.sum       = sum_ff;
   assign rsp.last      = last_ff;
   assign rsp.dim_error = dim_error_ff;

   // Checks on the sequencer and the pipe.
   `MMU_ASSERT_IMPL(a_ready_pipe_empty, clock, reset, req.ready, !s1_valid_ff && !s2_valid_ff)
   `MMU_ASSERT_IMPL(a_load_slot_free, clock, reset, out_load || err_load, !rsp_valid_ff || rsp.ready)
   `MMU_ASSERT_IMPL(a_pipe_busy_state, clock, reset, s1_valid_ff, state_ff != ST_IDLE)
   `MMU_ASSERT_NEXT(a_stall_holds_product, clock, reset, stall, $stable(prod_ff) && s2_valid_ff)

endmodule

`default_nettype wire
